// ===== src/integer_to_ascii_formatter_assert.svh =====
// Assertion macros shared by the integer-to-ASCII formatter modules.
// Each macro expects i_clk and i_rst_n to be visible in the enclosing module.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ITA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ita_pkg.sv =====
// Shared types, codes and character constants for the integer-to-ASCII formatter.
// No dependencies; the interfaces, front end, emitter and top level use it.
package ita_pkg;

    localparam int CHAR_W  = 8;
    localparam int WIDTH_W = 8;
    localparam int NDIG_W  = 4;
    localparam int PAD_MAX = 14;

    localparam logic [1:0] OP_SDEC    = 2'd0;
    localparam logic [1:0] OP_UDEC    = 2'd1;
    localparam logic [1:0] OP_HEX     = 2'd2;
    localparam logic [1:0] OP_HEX_ALT = 2'd3;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_F = 8'h66;

    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        EM_IDLE,
        EM_SIGN_PRE,
        EM_PAD,
        EM_SIGN_POST,
        EM_DIGITS
    } t_emit_state;

    // Classification of one number, passed from the front end to the emitter.
    typedef struct packed {
        logic               neg;
        logic               zero_fill;
        logic [WIDTH_W-1:0] width;
        logic [NDIG_W-1:0]  ndig;
    } t_fmt;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        return DIGIT_CHARS[d];
    endfunction

endpackage

// ===== src/ita_if.sv =====
// Valid/ready channel interfaces of the integer-to-ASCII formatter.
// Uses ita_pkg for the fixed field widths.
interface ita_in_if #(
    parameter int VALUE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic [VALUE_BITS-1:0]        value;
    logic [ita_pkg::WIDTH_W-1:0]  width;
    logic                         zero_fill;

    modport source (output valid, output op, output value, output width,
                    output zero_fill, input ready);
    modport sink   (input valid, input op, input value, input width,
                    input zero_fill, output ready);
endinterface

interface ita_out_if;
    logic                         valid;
    logic                         ready;
    logic [ita_pkg::CHAR_W-1:0]   char_out;
    logic                         last;

    modport source (output valid, output char_out, output last, input ready);
    modport sink   (input valid, input char_out, input last, output ready);
endinterface

// ===== src/integer_to_ascii_formatter.sv =====
// Top level of the integer-to-ASCII formatter: front end, item queue and emitter.
// Depends on ita_pkg, ita_if.sv, ita_front, ita_fifo and ita_back.
//
// Usage: i_in carries one number per item (op, value, width, zero_fill) on a
// valid/ready handshake; o_out returns the formatted text one ASCII character
// per item, with last set on the final character of each number.
// Decimal numbers are converted by a shift-and-add-3 unit that takes one value
// bit per cycle; hex numbers need no conversion. The emitter then produces one
// character per cycle while the receiver is ready (1 to 20 characters per number
// at VALUE_BITS = 16), running back to back across numbers. Sustained throughput
// is set by the slower of the front end and the emitter.
// The queue holds QUEUE_DEPTH converted numbers, so the front end keeps taking
// items while the emitter waits on a stalled receiver; a full queue then drops
// i_in.ready once the front end holds a converted number that it cannot push.
// A stalled receiver holds the current character steady.
// A synchronous reset empties the queue and clears both state machines; no
// clearing pass is needed and items are accepted in the first cycle after reset.
module integer_to_ascii_formatter #(
    parameter int VALUE_BITS  = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ita_in_if.sink      i_in,
    ita_out_if.source   o_out
);

    // Decimal digit count of 2^VALUE_BITS - 1 is floor(VALUE_BITS * log10(2)) + 1.
    localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIG_W      = 4 * NDIG;
    localparam int ENT_W      = $bits(ita_pkg::t_fmt) + DIG_W;

    logic               push;
    logic               full;
    logic               pop;
    logic               empty;
    ita_pkg::t_fmt      front_fmt;
    logic [DIG_W-1:0]   front_digits;
    logic [ENT_W-1:0]   q_out;

    // The front end converts the value and classifies sign and width.
    ita_front #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_push   (push),
        .i_full   (full),
        .o_fmt    (front_fmt),
        .o_digits (front_digits)
    );

    // Converted numbers wait here so each side can stall on its own.
    ita_fifo #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data ({front_fmt, front_digits}),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (q_out),
        .o_empty     (empty)
    );

    // The emitter sequences sign, padding and digits into the output register.
    ita_back #(
        .NDIG  (NDIG),
        .ENT_W (ENT_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .o_pop   (pop),
        .i_entry (q_out),
        .o_out   (o_out)
    );

endmodule

// ===== src/ita_front.sv =====
// Front end: accepts items, takes the magnitude and converts it to BCD or hex nibbles.
// Depends on ita_pkg, ita_if.sv and integer_to_ascii_formatter_assert.svh.
`include "integer_to_ascii_formatter_assert.svh"

module ita_front #(
    parameter int VALUE_BITS = 16,
    parameter int NDIG       = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    ita_in_if.sink                 i_in,
    output logic                   o_push,
    input  logic                   i_full,
    output ita_pkg::t_fmt          o_fmt,
    output logic [4*NDIG-1:0]      o_digits
);

    localparam int DIG_W  = 4 * NDIG;
    localparam int STEP_W = $clog2(VALUE_BITS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VALUE_BITS - 1);

    ita_pkg::t_front_state r_state, n_state;

    logic [STEP_W-1:0]             r_cnt;
    logic [VALUE_BITS-1:0]         r_shift;
    logic [DIG_W-1:0]              r_bcd;
    logic                          r_neg;
    logic                          r_zf;
    logic [ita_pkg::WIDTH_W-1:0]   r_width;

    logic                          accept;
    logic                          in_hex;
    logic                          in_neg;
    logic [VALUE_BITS-1:0]         in_mag;
    logic [DIG_W-1:0]              adj;
    logic [DIG_W-1:0]              n_bcd;
    logic [VALUE_BITS-1:0]         n_shift;
    logic [ita_pkg::NDIG_W-1:0]    n_ndig;

    // Classify the incoming item.
    always_comb begin
        case (i_in.op)
            ita_pkg::OP_SDEC, ita_pkg::OP_UDEC: in_hex = 1'b0;
            default:                            in_hex = 1'b1;
        endcase
        in_neg = (i_in.op == ita_pkg::OP_SDEC) && i_in.value[VALUE_BITS-1];
        in_mag = in_neg ? (~i_in.value + VALUE_BITS'(1)) : i_in.value;
    end

    // Handshake and next state.
    always_comb begin
        i_in.ready = (r_state == ita_pkg::FR_IDLE) ||
                     ((r_state == ita_pkg::FR_PUSH) && !i_full);
        o_push     = (r_state == ita_pkg::FR_PUSH) && !i_full;
        accept     = i_in.valid && i_in.ready;
        n_state    = r_state;
        case (r_state)
            ita_pkg::FR_IDLE: begin
                if (accept) begin
                    n_state = in_hex ? ita_pkg::FR_PUSH : ita_pkg::FR_CONV;
                end
            end
            ita_pkg::FR_CONV: begin
                if (r_cnt == STEP_LAST) begin
                    n_state = ita_pkg::FR_PUSH;
                end
            end
            ita_pkg::FR_PUSH: begin
                if (!i_full) begin
                    if (accept) begin
                        n_state = in_hex ? ita_pkg::FR_PUSH : ita_pkg::FR_CONV;
                    end else begin
                        n_state = ita_pkg::FR_IDLE;
                    end
                end
            end
            default: n_state = ita_pkg::FR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ita_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // One double-dabble step: adjust each BCD digit, then shift in one bit.
    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? (r_bcd[4*k +: 4] + 4'd3)
                                                      : r_bcd[4*k +: 4];
        end
        n_bcd   = {adj[DIG_W-2:0], r_shift[VALUE_BITS-1]};
        n_shift = {r_shift[VALUE_BITS-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= '0;
        end else if (r_state == ita_pkg::FR_CONV) begin
            r_cnt <= r_cnt + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg   <= in_neg;
            r_zf    <= i_in.zero_fill;
            r_width <= i_in.width;
            if (in_hex) begin
                r_bcd <= DIG_W'(in_mag);
            end else begin
                r_bcd   <= '0;
                r_shift <= in_mag;
            end
        end else if (r_state == ita_pkg::FR_CONV) begin
            r_bcd   <= n_bcd;
            r_shift <= n_shift;
        end
    end

    // Significant digit count: highest non-zero nibble, at least one digit.
    always_comb begin
        n_ndig = ita_pkg::NDIG_W'(1);
        for (int k = 1; k < NDIG; k++) begin
            if (r_bcd[4*k +: 4] != 4'd0) begin
                n_ndig = ita_pkg::NDIG_W'(k + 1);
            end
        end
    end

    assign o_fmt    = '{neg: r_neg, zero_fill: r_zf, width: r_width, ndig: n_ndig};
    assign o_digits = r_bcd;

    `ITA_ASSERT_SAME(a_conv_blocks_input, r_state == ita_pkg::FR_CONV, !i_in.ready, "front accepts during conversion")
    `ITA_ASSERT_SAME(a_push_count_range, o_push, (n_ndig != '0) && (n_ndig <= ita_pkg::NDIG_W'(NDIG)), "digit count out of range")

endmodule

// ===== src/ita_fifo.sv =====
// Small register queue between the front end and the character emitter.
// Depends on integer_to_ascii_formatter_assert.svh.
`include "integer_to_ascii_formatter_assert.svh"

module ita_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full     = (r_count == CNT_FULL);
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `ITA_ASSERT_SAME(a_no_overflow, i_push, !o_full || i_pop, "push into a full queue")

endmodule

// ===== src/ita_back.sv =====
// Character emitter: walks sign, padding and digits of one queued number per run.
// Depends on ita_pkg, ita_if.sv and integer_to_ascii_formatter_assert.svh.
`include "integer_to_ascii_formatter_assert.svh"

module ita_back #(
    parameter int NDIG  = 5,
    parameter int ENT_W = $bits(ita_pkg::t_fmt) + 4 * NDIG
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    output logic             o_pop,
    input  logic [ENT_W-1:0] i_entry,
    ita_out_if.source        o_out
);

    localparam int DIG_W = 4 * NDIG;
    localparam int FMT_W = $bits(ita_pkg::t_fmt);
    localparam int IDX_W = $clog2(NDIG);

    ita_pkg::t_emit_state r_state, n_state;

    ita_pkg::t_fmt              fmt;
    logic [DIG_W-1:0]           ent_digits;
    logic signed [9:0]          pad_raw;
    logic [3:0]                 ld_pad;
    ita_pkg::t_emit_state       ld_state;

    logic                       r_neg;
    logic                       r_zf;
    logic [3:0]                 r_pad;
    logic [IDX_W-1:0]           r_idx;
    logic [DIG_W-1:0]           r_digits;
    logic                       r_out_valid;
    logic [ita_pkg::CHAR_W-1:0] r_char;
    logic                       r_last;

    logic                       adv;
    logic                       emit;
    logic                       load;
    logic                       em_final;
    logic [ita_pkg::CHAR_W-1:0] em_char;
    ita_pkg::t_emit_state       em_next;

    assign fmt        = i_entry[ENT_W-1 -: FMT_W];
    assign ent_digits = i_entry[DIG_W-1:0];

    // Padding of the queued number and the phase its run starts in.
    always_comb begin
        pad_raw = $signed({2'b00, fmt.width}) - $signed({6'b000000, fmt.ndig})
                  - $signed({9'b000000000, fmt.neg});
        if ((pad_raw >= 10'sd1) && (pad_raw <= 10'(ita_pkg::PAD_MAX))) begin
            ld_pad = pad_raw[3:0];
        end else begin
            ld_pad = 4'd0;
        end
        if (fmt.neg && fmt.zero_fill) begin
            ld_state = ita_pkg::EM_SIGN_PRE;
        end else if (ld_pad != 4'd0) begin
            ld_state = ita_pkg::EM_PAD;
        end else if (fmt.neg) begin
            ld_state = ita_pkg::EM_SIGN_POST;
        end else begin
            ld_state = ita_pkg::EM_DIGITS;
        end
    end

    // Character of the current phase and the phase that follows it.
    always_comb begin
        adv      = !r_out_valid || o_out.ready;
        emit     = adv && (r_state != ita_pkg::EM_IDLE);
        em_final = 1'b0;
        em_char  = ita_pkg::CH_SPACE;
        em_next  = r_state;
        case (r_state)
            ita_pkg::EM_SIGN_PRE: begin
                em_char = ita_pkg::CH_MINUS;
                em_next = (r_pad != 4'd0) ? ita_pkg::EM_PAD : ita_pkg::EM_DIGITS;
            end
            ita_pkg::EM_PAD: begin
                em_char = r_zf ? ita_pkg::CH_ZERO : ita_pkg::CH_SPACE;
                if (r_pad == 4'd1) begin
                    em_next = (r_neg && !r_zf) ? ita_pkg::EM_SIGN_POST : ita_pkg::EM_DIGITS;
                end
            end
            ita_pkg::EM_SIGN_POST: begin
                em_char = ita_pkg::CH_MINUS;
                em_next = ita_pkg::EM_DIGITS;
            end
            ita_pkg::EM_DIGITS: begin
                em_char  = ita_pkg::digit_char(r_digits[r_idx*4 +: 4]);
                em_final = (r_idx == '0);
                if (em_final) begin
                    em_next = ita_pkg::EM_IDLE;
                end
            end
            default: em_next = ita_pkg::EM_IDLE;
        endcase

        load  = !i_empty && ((r_state == ita_pkg::EM_IDLE) || (emit && em_final));
        o_pop = load;

        n_state = r_state;
        if (load) begin
            n_state = ld_state;
        end else if (emit) begin
            n_state = em_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ita_pkg::EM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad <= 4'd0;
            r_idx <= '0;
        end else if (load) begin
            r_pad <= ld_pad;
            r_idx <= IDX_W'(fmt.ndig - ita_pkg::NDIG_W'(1));
        end else if (emit) begin
            if (r_state == ita_pkg::EM_PAD) begin
                r_pad <= r_pad - 4'd1;
            end
            if ((r_state == ita_pkg::EM_DIGITS) && !em_final) begin
                r_idx <= r_idx - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_neg    <= fmt.neg;
            r_zf     <= fmt.zero_fill;
            r_digits <= ent_digits;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= em_char;
            r_last <= em_final;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.char_out = r_char;
    assign o_out.last     = r_last;

    `ITA_ASSERT_SAME(a_pad_nonzero, r_state == ita_pkg::EM_PAD, r_pad != 4'd0, "padding phase with no padding left")
    `ITA_ASSERT_SAME(a_last_is_digit, o_out.valid && o_out.last, ((o_out.char_out >= ita_pkg::CH_ZERO) && (o_out.char_out <= ita_pkg::CH_NINE)) || ((o_out.char_out >= ita_pkg::CH_LOW_A) && (o_out.char_out <= ita_pkg::CH_LOW_F)), "last character is not a digit")

endmodule
